// ===== hw/rtl/rbqs_pkg.sv =====
package rbqs_pkg;

  localparam int QualityBins = 64;
  localparam int CounterBits = 48;
  localparam int FieldBits   = 48;
  localparam int BinBits     = $clog2(QualityBins);
  localparam int WalkBits    = BinBits + 1;
  localparam int NumClasses  = 5;
  localparam int PhredOffset = 33;
  localparam int Q20Level    = 20;
  localparam int Q30Level    = 30;
  localparam int CmdDepth    = 4;
  localparam int CmdPtrBits  = $clog2(CmdDepth);

  typedef logic [CounterBits-1:0] counter_t;
  typedef logic [FieldBits-1:0]   field_t;
  typedef logic [BinBits-1:0]     bin_t;

  typedef enum logic [1:0] {
    MODE_BASE     = 2'd0,
    MODE_READ_END = 2'd1,
    MODE_REPORT   = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_BASE,
    OP_READ_END,
    OP_REPORT
  } cmd_op_t;

  typedef enum logic [2:0] {
    CLS_A,
    CLS_C,
    CLS_G,
    CLS_T,
    CLS_OTHER
  } class_t;

  typedef struct packed {
    cmd_op_t op;
    class_t  cls;
    bin_t    bin;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_WALK,
    ST_FINISH
  } back_state_t;

  typedef struct packed {
    logic walking;
    logic finishing;
  } back_status_t;

  function automatic counter_t sat_add(input counter_t a, input counter_t b);
    logic [CounterBits:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CounterBits] ? {CounterBits{1'b1}} : sum[CounterBits-1:0];
  endfunction

endpackage

// ===== hw/rtl/rbqs_front.sv =====
module rbqs_front (
  input  logic                push,
  input  logic [1:0]          mode,
  input  logic [7:0]          base_char,
  input  logic [7:0]          quality_char,
  input  logic                cmd_full,
  output logic                cmd_wr,
  output rbqs_pkg::cmd_t      cmd
);
  import rbqs_pkg::*;

  logic [7:0] upper_char;
  logic [7:0] qual_off;

  // Clearing bit 5 folds lower-case letters onto upper case.
  assign upper_char = base_char & 8'hDF;
  assign qual_off   = quality_char - 8'(PhredOffset);

  always_comb begin
    cmd.op  = OP_BASE;
    cmd_wr  = 1'b0;
    unique case (mode)
      MODE_BASE: begin
        cmd.op = OP_BASE;
        cmd_wr = push && !cmd_full;
      end
      MODE_READ_END: begin
        cmd.op = OP_READ_END;
        cmd_wr = push && !cmd_full;
      end
      MODE_REPORT: begin
        cmd.op = OP_REPORT;
        cmd_wr = push && !cmd_full;
      end
      MODE_UNUSED: begin
        cmd.op = OP_BASE;
        cmd_wr = 1'b0;
      end
      default: begin
        cmd.op = OP_BASE;
        cmd_wr = 1'b0;
      end
    endcase

    unique case (upper_char)
      8'h41:   cmd.cls = CLS_A;
      8'h43:   cmd.cls = CLS_C;
      8'h47:   cmd.cls = CLS_G;
      8'h54:   cmd.cls = CLS_T;
      default: cmd.cls = CLS_OTHER;
    endcase

    priority if (quality_char < 8'(PhredOffset)) begin
      cmd.bin = '0;
    end else if (qual_off > 8'(QualityBins - 1)) begin
      cmd.bin = BinBits'(QualityBins - 1);
    end else begin
      cmd.bin = qual_off[BinBits-1:0];
    end
  end

endmodule

// ===== hw/rtl/rbqs_cmd_fifo.sv =====
module rbqs_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rbqs_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output rbqs_pkg::cmd_t rd_data,
  output logic           rd_valid
);
  import rbqs_pkg::*;

  cmd_t                  slots [CmdDepth];
  logic [CmdPtrBits-1:0] wr_ptr;
  logic [CmdPtrBits-1:0] rd_ptr;
  logic [CmdPtrBits:0]   count;

  assign full     = (count == (CmdPtrBits + 1)'(CmdDepth));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rbqs_back.sv =====
module rbqs_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  rbqs_pkg::cmd_t         cmd,
  output logic                   cmd_rd,
  input  logic                   pop,
  output logic                   empty,
  output rbqs_pkg::field_t       read_count,
  output rbqs_pkg::field_t       total_bases,
  output rbqs_pkg::field_t       q20_bases,
  output rbqs_pkg::field_t       q30_bases,
  output rbqs_pkg::field_t       gc_bases,
  output rbqs_pkg::back_status_t status
);
  import rbqs_pkg::*;

  back_state_t state, state_next;

  counter_t             hist_mem [QualityBins];
  logic [QualityBins-1:0] hist_valid;
  counter_t             rd_data;
  bin_t                 rd_addr;

  // Update stage: holds the request whose histogram read is in flight.
  logic    b_valid;
  cmd_op_t b_op;
  class_t  b_cls;
  bin_t    b_bin;

  // The previous update, forwarded when the same bin is hit twice in a row.
  logic     last_wr_valid;
  bin_t     last_wr_bin;
  counter_t last_wr_val;

  counter_t class_cnt [NumClasses];
  counter_t reads_seen;

  logic [WalkBits-1:0] walk_idx;
  logic                walk_issue;
  logic                acc_valid;
  bin_t                acc_bin;
  counter_t            acc_hist;
  counter_t            acc_total;
  counter_t            acc_q20;
  counter_t            acc_q30;

  logic     res_valid;
  counter_t cur_hist;
  counter_t hist_inc;
  logic     hist_wr;
  logic     start_walk;
  logic     load_result;
  logic     issue_update;

  assign cur_hist = (last_wr_valid && (last_wr_bin == b_bin)) ? last_wr_val :
                    (hist_valid[b_bin] ? rd_data : '0);
  assign hist_inc = sat_add(cur_hist, CounterBits'(1));
  assign hist_wr  = b_valid && (b_op == OP_BASE);
  assign acc_hist = hist_valid[acc_bin] ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd_rd       = 1'b0;
    start_walk   = 1'b0;
    issue_update = 1'b0;
    load_result  = 1'b0;
    walk_issue   = 1'b0;
    rd_addr      = cmd.bin;
    unique case (state)
      ST_RUN: begin
        if (cmd_valid) begin
          if (cmd.op != OP_REPORT) begin
            cmd_rd       = 1'b1;
            issue_update = 1'b1;
          end else if (!b_valid && !res_valid) begin
            cmd_rd     = 1'b1;
            start_walk = 1'b1;
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_addr    = walk_idx[BinBits-1:0];
        walk_issue = (walk_idx < WalkBits'(QualityBins));
        if (acc_valid && (acc_bin == BinBits'(QualityBins - 1))) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        load_result = 1'b1;
        state_next  = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  assign status.walking   = (state == ST_WALK);
  assign status.finishing = load_result;

  always_ff @(posedge clk) begin
    rd_data <= hist_mem[rd_addr];
    if (hist_wr) begin
      hist_mem[b_bin] <= hist_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid    <= '0;
      b_valid       <= 1'b0;
      last_wr_valid <= 1'b0;
      acc_valid     <= 1'b0;
      res_valid     <= 1'b0;
      reads_seen    <= '0;
      walk_idx      <= '0;
      for (int i = 0; i < NumClasses; i++) begin
        class_cnt[i] <= '0;
      end
    end else begin
      b_valid       <= issue_update;
      last_wr_valid <= hist_wr;
      acc_valid     <= walk_issue;
      if (hist_wr) begin
        hist_valid[b_bin] <= 1'b1;
        class_cnt[b_cls]  <= sat_add(class_cnt[b_cls], CounterBits'(1));
      end
      if (b_valid && (b_op == OP_READ_END)) begin
        reads_seen <= sat_add(reads_seen, CounterBits'(1));
      end
      if (start_walk) begin
        walk_idx <= '0;
      end else if (walk_issue) begin
        walk_idx <= walk_idx + 1'b1;
      end
      if (load_result) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_update) begin
      b_op  <= cmd.op;
      b_cls <= cmd.cls;
      b_bin <= cmd.bin;
    end
    if (hist_wr) begin
      last_wr_bin <= b_bin;
      last_wr_val <= hist_inc;
    end
    acc_bin <= walk_idx[BinBits-1:0];
    if (start_walk) begin
      acc_total <= '0;
      acc_q20   <= '0;
      acc_q30   <= '0;
    end else if (acc_valid) begin
      if (acc_bin >= BinBits'(Q20Level)) begin
        acc_q20 <= sat_add(acc_q20, acc_hist);
      end
      if (acc_bin >= BinBits'(Q30Level)) begin
        acc_q30 <= sat_add(acc_q30, acc_hist);
      end
      // The first few walk steps also fold in the base class counters.
      if (acc_bin < BinBits'(NumClasses)) begin
        acc_total <= sat_add(acc_total, class_cnt[acc_bin[2:0]]);
      end
    end
    if (load_result) begin
      read_count  <= FieldBits'(reads_seen);
      total_bases <= FieldBits'(acc_total);
      q20_bases   <= FieldBits'(acc_q20);
      q30_bases   <= FieldBits'(acc_q30);
      gc_bases    <= FieldBits'(sat_add(class_cnt[CLS_C], class_cnt[CLS_G]));
    end
  end

  assign empty = !res_valid;

endmodule

// ===== hw/rtl/read_base_quality_statistics_unit.sv =====
// Channel   Handshake          Payload
// request   push / full        mode, base_char, quality_char
// result    empty / pop        read_count, total_bases, q20_bases, q30_bases, gc_bases
//
// Base and end-of-read requests are taken one per cycle unless the queue is full;
// bases update their histogram bin by read-modify-write on one read and one write port.
// A report waits for the update stage to drain and the result register to be free,
// then walks all QualityBins bins, one read a cycle.
// Requests keep being taken into a four-entry queue while a report runs or a result waits.
// Reset clears the counters and the per-bin valid bits at once; no clearing pass is needed.
module read_base_quality_statistics_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             mode,
  input  logic [7:0]             base_char,
  input  logic [7:0]             quality_char,
  output logic                   empty,
  input  logic                   pop,
  output rbqs_pkg::field_t       read_count,
  output rbqs_pkg::field_t       total_bases,
  output rbqs_pkg::field_t       q20_bases,
  output rbqs_pkg::field_t       q30_bases,
  output rbqs_pkg::field_t       gc_bases
);
  import rbqs_pkg::*;

  logic         cmd_wr;
  cmd_t         cmd_in;
  logic         cmd_full;
  logic         cmd_rd;
  cmd_t         cmd_head;
  logic         cmd_valid;
  back_status_t status;

  assign full = cmd_full;

  rbqs_front u_front (
    .push         (push),
    .mode         (mode),
    .base_char    (base_char),
    .quality_char (quality_char),
    .cmd_full     (cmd_full),
    .cmd_wr       (cmd_wr),
    .cmd          (cmd_in)
  );

  rbqs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cmd_wr),
    .wr_data  (cmd_in),
    .full     (cmd_full),
    .rd_en    (cmd_rd),
    .rd_data  (cmd_head),
    .rd_valid (cmd_valid)
  );

  rbqs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd_head),
    .cmd_rd      (cmd_rd),
    .pop         (pop),
    .empty       (empty),
    .read_count  (read_count),
    .total_bases (total_bases),
    .q20_bases   (q20_bases),
    .q30_bases   (q30_bases),
    .gc_bases    (gc_bases),
    .status      (status)
  );

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_wr && cmd_full))
    else $error("request written into a full queue");

  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(status.finishing))
    else $error("result appeared without a finished histogram walk");

  a_finish_gives_result: assert property (@(posedge clk) disable iff (rst)
    status.finishing |=> !empty)
    else $error("finished report did not present a result");

  a_walk_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.walking && status.finishing))
    else $error("walk and finish active together");

endmodule

// ===== bench/tb.sv =====
module tb;
  import rbqs_pkg::*;

  typedef struct {
    mode_t      mode;
    logic [7:0] base_char;
    logic [7:0] quality_char;
    bit         drain_first;
  } request_t;

  typedef struct {
    field_t read_count;
    field_t total_bases;
    field_t q20_bases;
    field_t q30_bases;
    field_t gc_bases;
  } stats_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [1:0] mode = MODE_BASE;
  logic [7:0] base_char = 8'h00;
  logic [7:0] quality_char = 8'h00;
  logic       full;
  logic       empty;
  field_t     read_count;
  field_t     total_bases;
  field_t     q20_bases;
  field_t     q30_bases;
  field_t     gc_bases;

  read_base_quality_statistics_unit uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .base_char    (base_char),
    .quality_char (quality_char),
    .empty        (empty),
    .pop          (pop),
    .read_count   (read_count),
    .total_bases  (total_bases),
    .q20_bases    (q20_bases),
    .q30_bases    (q30_bases),
    .gc_bases     (gc_bases)
  );

  // Predicted state of the statistics block.
  counter_t reads_ended;
  counter_t class_tally [NumClasses];
  counter_t quality_tally [QualityBins];

  request_t    pending [$];
  stats_t      owed_stats [$];
  bit          req_fire = 1'b0;
  bit          res_fire = 1'b0;
  int unsigned reqs_taken = 0;
  int unsigned bases_taken = 0;
  int unsigned read_ends_taken = 0;
  int unsigned reports_taken = 0;
  int unsigned reports_checked = 0;
  int unsigned failures = 0;
  int unsigned send_gap = 0;
  int unsigned pop_wait = 0;
  int unsigned long_hold = 0;
  int unsigned hold_mark = 0;
  bit          hold_done = 1'b0;
  int unsigned reports_queued = 0;

  logic [7:0] nucleotides [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

  function automatic counter_t capped_sum(counter_t a, counter_t b);
    logic [CounterBits:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[CounterBits] ? {CounterBits{1'b1}} : wide[CounterBits-1:0];
  endfunction

  function automatic class_t classify_base(logic [7:0] ch);
    case (ch)
      "A", "a": return CLS_A;
      "C", "c": return CLS_C;
      "G", "g": return CLS_G;
      "T", "t": return CLS_T;
      default:  return CLS_OTHER;
    endcase
  endfunction

  // Qualities below the Phred offset fall into the bottom bin, and those past
  // the last bin are clamped into the top one.
  function automatic int quality_bin_of(logic [7:0] qc);
    if (qc < PhredOffset) return 0;
    if (qc - PhredOffset > QualityBins - 1) return QualityBins - 1;
    return qc - PhredOffset;
  endfunction

  function automatic stats_t predict_report();
    stats_t   s;
    counter_t total;
    counter_t q20;
    counter_t q30;
    total = '0;
    q20 = '0;
    q30 = '0;
    for (int i = 0; i < NumClasses; i++) total = capped_sum(total, class_tally[i]);
    for (int i = 0; i < QualityBins; i++) begin
      if (i >= Q20Level) q20 = capped_sum(q20, quality_tally[i]);
      if (i >= Q30Level) q30 = capped_sum(q30, quality_tally[i]);
    end
    s.read_count = reads_ended;
    s.total_bases = total;
    s.q20_bases = q20;
    s.q30_bases = q30;
    s.gc_bases = capped_sum(class_tally[CLS_C], class_tally[CLS_G]);
    return s;
  endfunction

  task automatic tally_request(logic [1:0] m, logic [7:0] bc, logic [7:0] qc);
    class_t cls;
    int     bin;
    case (m)
      MODE_BASE: begin
        cls = classify_base(bc);
        bin = quality_bin_of(qc);
        class_tally[cls] = capped_sum(class_tally[cls], CounterBits'(1));
        quality_tally[bin] = capped_sum(quality_tally[bin], CounterBits'(1));
        bases_taken++;
      end
      MODE_READ_END: begin
        reads_ended = capped_sum(reads_ended, CounterBits'(1));
        read_ends_taken++;
      end
      MODE_REPORT: begin
        owed_stats.push_back(predict_report());
        reports_taken++;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, field_t want, field_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic compare_stats();
    stats_t want;
    if (owed_stats.size() == 0) begin
      $error("result arrived with no report request outstanding");
      failures++;
    end else begin
      want = owed_stats.pop_front();
      check_field("read_count", want.read_count, read_count);
      check_field("total_bases", want.total_bases, total_bases);
      check_field("q20_bases", want.q20_bases, q20_bases);
      check_field("q30_bases", want.q30_bases, q30_bases);
      check_field("gc_bases", want.gc_bases, gc_bases);
      reports_checked++;
    end
  endtask

  task automatic queue_request(mode_t m, logic [7:0] bc, logic [7:0] qc, bit drain);
    request_t r;
    r.mode = m;
    r.base_char = bc;
    r.quality_char = qc;
    r.drain_first = drain;
    pending.push_back(r);
    if (m == MODE_REPORT) reports_queued++;
  endtask

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_base();
    if ($urandom_range(0, 7) == 0) return random_byte();
    return nucleotides[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] random_quality();
    if ($urandom_range(0, 7) == 0) return random_byte();
    return 8'(PhredOffset + $urandom_range(0, 45));
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  // Monitor: results are checked before the request of the same edge is applied,
  // since a result can never come from a request taken at that very edge.
  always @(posedge clk) begin
    req_fire = !rst && push && !full;
    res_fire = !rst && pop && !empty;
    if (res_fire) compare_stats();
    if (req_fire) begin
      tally_request(mode, base_char, quality_char);
      reqs_taken++;
    end
  end

  always @(negedge clk) begin : send_requests
    request_t nxt;
    if (!rst && !(push && !req_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending.size() > 0 &&
                   !(pending[0].drain_first && owed_stats.size() > 0)) begin
        nxt = pending.pop_front();
        push <= 1'b1;
        mode <= nxt.mode;
        base_char <= nxt.base_char;
        quality_char <= nxt.quality_char;
        send_gap = ((reqs_taken % 200) < 50) ? 0 : $urandom_range(0, 7);
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : take_results
    if (!rst) begin
      if (res_fire) pop_wait = ((reports_checked % 10) < 3) ? 0 : $urandom_range(0, 7);
      if (!hold_done && hold_mark != 0 && reqs_taken >= hold_mark) begin
        long_hold = 300;
        hold_done = 1'b1;
      end
      if (long_hold > 0) begin
        long_hold--;
        pop <= 1'b0;
      end else if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #(20 * 400000);
    $display("tb failed");
    $finish;
  end

  initial begin
    int unsigned len;
    reads_ended = '0;
    for (int i = 0; i < NumClasses; i++) class_tally[i] = '0;
    for (int i = 0; i < QualityBins; i++) quality_tally[i] = '0;

    // Directed part: every class in both cases, the quality edges around the
    // offset, the Q20 and Q30 levels and the top bin, ignored fields and mode 3.
    queue_request(MODE_REPORT, 8'h00, 8'h00, 1'b0);
    queue_request(MODE_BASE, "A", 8'd0, 1'b0);
    queue_request(MODE_BASE, "a", 8'd32, 1'b0);
    queue_request(MODE_BASE, "C", 8'd33, 1'b0);
    queue_request(MODE_BASE, "c", 8'd52, 1'b0);
    queue_request(MODE_BASE, "G", 8'd53, 1'b0);
    queue_request(MODE_BASE, "g", 8'd62, 1'b0);
    queue_request(MODE_BASE, "T", 8'd63, 1'b0);
    queue_request(MODE_BASE, "t", 8'd96, 1'b0);
    queue_request(MODE_BASE, "N", 8'd97, 1'b0);
    queue_request(MODE_BASE, 8'h00, 8'hFF, 1'b0);
    queue_request(MODE_BASE, 8'hFF, "I", 1'b0);
    queue_request(MODE_READ_END, 8'hFF, 8'hFF, 1'b0);
    queue_request(MODE_UNUSED, "G", "I", 1'b0);
    queue_request(MODE_REPORT, 8'hFF, 8'h00, 1'b0);
    queue_request(MODE_READ_END, "C", 8'h00, 1'b0);
    queue_request(MODE_REPORT, 8'h55, 8'hAA, 1'b1);

    // Random part: mostly whole reads with a report after many of them.
    while (pending.size() < 1150 || reports_queued < 45) begin
      if (hold_mark == 0 && pending.size() >= 300) begin
        // Reports packed closely while the receiver holds off fill the block.
        hold_mark = pending.size();
        for (int i = 0; i < 8; i++) begin
          queue_request(MODE_REPORT, random_byte(), random_byte(), 1'b0);
          queue_request(MODE_BASE, random_base(), random_quality(), 1'b0);
          queue_request(MODE_BASE, random_base(), random_quality(), 1'b0);
        end
      end
      case ($urandom_range(0, 15))
        0: queue_request(MODE_UNUSED, random_byte(), random_byte(), 1'b0);
        1: queue_request(MODE_READ_END, random_byte(), random_byte(), 1'b0);
        default: begin
          len = $urandom_range(1, 24);
          for (int i = 0; i < len; i++) begin
            queue_request(MODE_BASE, random_base(), random_quality(), 1'b0);
            if ($urandom_range(0, 39) == 0)
              queue_request(MODE_REPORT, random_byte(), random_byte(), 1'b0);
          end
          queue_request(MODE_READ_END, random_byte(), random_byte(), 1'b0);
          if ($urandom_range(0, 1) == 0)
            queue_request(MODE_REPORT, random_byte(), random_byte(),
                          $urandom_range(0, 19) == 0);
        end
      endcase
    end
    queue_request(MODE_REPORT, random_byte(), random_byte(), 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || push) @(negedge clk);
    while (owed_stats.size() != 0) @(negedge clk);
    repeat (2 * QualityBins + 16) @(negedge clk);

    $display("Applied %0d requests: %0d bases, %0d read ends, %0d reports.",
             reqs_taken, bases_taken, read_ends_taken, reports_taken);
    $display("Compared %0d report results field by field; %0d failures.",
             reports_checked, failures);
    if (failures == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rbqs_pkg.sv
hw/rtl/rbqs_front.sv
hw/rtl/rbqs_cmd_fifo.sv
hw/rtl/rbqs_back.sv
hw/rtl/read_base_quality_statistics_unit.sv
bench/tb.sv
